// ----- sv/skm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package skm_pkg;

    localparam int WORDS_MAX   = 4096;
    localparam int DIM_MAX     = 128;
    localparam int CLASSES_MAX = 64;

    localparam int W_AW    = $clog2(WORDS_MAX);
    localparam int D_AW    = $clog2(DIM_MAX);
    localparam int C_AW    = $clog2(CLASSES_MAX);
    localparam int WCNT_W  = W_AW + 1;
    localparam int VEC_AW  = W_AW + D_AW;
    localparam int CENT_AW = C_AW + D_AW;

    localparam int ELEM_W   = 16;
    localparam int CENT_W   = 32;
    localparam int MEMB_W   = W_AW + 1;
    localparam int SQ_W     = 40;
    localparam int LEN_W    = SQ_W / 2;
    localparam int NUM_W    = 48;
    localparam int DIV_MAG_W = NUM_W - 1;
    localparam int DIV_CNT_W = $clog2(DIV_MAG_W + 1);
    localparam int QUO_W    = 32;
    localparam int PROD_W   = CENT_W + ELEM_W;
    localparam int DOT_W    = PROD_W + D_AW;
    localparam int UNIT_SHIFT = 30;

    localparam int CC_W   = 7;
    localparam int VL_W   = 8;
    localparam int PC_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CC_W-1:0] CLASS_COUNT_RST   = CC_W'(1);
    localparam logic [VL_W-1:0] VECTOR_LENGTH_RST = VL_W'(100);
    localparam logic [PC_W-1:0] PASS_COUNT_RST    = PC_W'(10);

    // -10 in Q13.42
    localparam logic signed [DOT_W-1:0] BEST_INIT = DOT_W'(-64'sd43980465111040);

    localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT    = CFG_IDX_W'(2);

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_QUERY, OP_INIT_SETUP, OP_INIT_WR, OP_PASS_SETUP, OP_CLR,
        OP_ACC_SETUP, OP_ACC_CLS_RD, OP_ACC_CLS, OP_ACC_RD, OP_ACC_WR,
        OP_NORM_SETUP, OP_NORM_RD, OP_NORM_GO, OP_NORM_WR, OP_SQRT_GO, OP_SQRT_END,
        OP_UNIT_RD, OP_UNIT_GO, OP_UNIT_WR,
        OP_ASG_SETUP, OP_ASG_CLS, OP_ASG_RD, OP_ASG_MUL, OP_ASG_ACC, OP_ASG_CMP,
        OP_ASG_NEXTC, OP_ASG_WR, OP_PASS_END
    } t_dp_op;

    typedef enum logic [4:0] {
        S_IDLE, S_QUERY, S_INIT_SETUP, S_INIT_WR, S_PASS_START, S_CLR,
        S_ACC_SETUP, S_ACC_CLS_RD, S_ACC_CLS, S_ACC_RD, S_ACC_WR,
        S_NORM_SETUP, S_NORM_RD, S_NORM_GO, S_NORM_WAIT, S_NORM_WR,
        S_SQRT_GO, S_SQRT_WAIT, S_SQRT_END,
        S_UNIT_RD, S_UNIT_GO, S_UNIT_WAIT, S_UNIT_WR,
        S_ASG_SETUP, S_ASG_CLS, S_ASG_RD, S_ASG_MUL, S_ASG_ACC, S_ASG_CMP,
        S_ASG_NEXTC, S_ASG_WR, S_PASS_END
    } t_state;

    typedef struct packed {
        t_dp_op op;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic w_last;
        logic d_last;
        logic c_last;
        logic pass_done;
        logic cent_ok;
        logic div_busy;
        logic sqrt_busy;
    } t_status;

endpackage
`default_nettype wire

// ----- sv/skm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module skm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- sv/skm_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module skm_div
    import skm_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [NUM_W-1:0] i_num,
    input  wire logic        [LEN_W-1:0] i_den,
    output logic                         o_busy,
    output logic signed [QUO_W-1:0]      o_quo
);
    logic                  r_busy, n_busy;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [DIV_MAG_W-1:0]  r_q, n_q;
    logic [LEN_W-1:0]      r_rem, n_rem;
    logic [LEN_W-1:0]      r_den, n_den;
    logic                  r_neg, n_neg;
    logic [NUM_W-1:0]      w_mag;
    logic [LEN_W:0]        w_trial;
    logic                  w_ge;

    // Restoring division on magnitudes, one quotient bit per cycle.
    always_comb begin
        w_mag   = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        w_trial = {r_rem, r_q[DIV_MAG_W-1]};
        w_ge    = w_trial >= {1'b0, r_den};
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_rem   = r_rem;
        n_den   = r_den;
        n_neg   = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_MAG_W);
            n_q    = w_mag[DIV_MAG_W-1:0];
            n_rem  = '0;
            n_den  = i_den;
            n_neg  = i_num[NUM_W-1];
        end else if (r_busy) begin
            n_rem = w_ge ? LEN_W'(w_trial - {1'b0, r_den}) : w_trial[LEN_W-1:0];
            n_q   = {r_q[DIV_MAG_W-2:0], w_ge};
            n_cnt = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_busy = r_busy;
    assign o_quo  = r_neg ? QUO_W'(-r_q[QUO_W-1:0]) : QUO_W'(r_q[QUO_W-1:0]);
endmodule
`default_nettype wire

// ----- sv/skm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module skm_ctrl
    import skm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire logic    i_operation,
    input  wire logic    i_last_in_vector,
    input  wire logic    i_last_vector,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_busy,
    output logic         o_result_valid
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_NONE;
        o_busy         = 1'b1;
        o_result_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_operation) begin
                        o_cmd.op = OP_QUERY;
                        n_state  = S_QUERY;
                    end else begin
                        o_cmd.op = OP_LOAD;
                        if (i_last_in_vector && i_last_vector) begin
                            n_state = S_INIT_SETUP;
                        end
                    end
                end
            end
            S_QUERY: begin
                o_result_valid = 1'b1;
                n_state        = S_IDLE;
            end
            S_INIT_SETUP: begin
                o_cmd.op = OP_INIT_SETUP;
                n_state  = i_status.n_zero ? S_PASS_START : S_INIT_WR;
            end
            S_INIT_WR: begin
                o_cmd.op = OP_INIT_WR;
                if (i_status.w_last) n_state = S_PASS_START;
            end
            S_PASS_START: begin
                o_cmd.op = OP_PASS_SETUP;
                n_state  = i_status.pass_done ? S_IDLE : S_CLR;
            end
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_status.d_last && i_status.c_last) n_state = S_ACC_SETUP;
            end
            S_ACC_SETUP: begin
                o_cmd.op = OP_ACC_SETUP;
                n_state  = i_status.n_zero ? S_NORM_SETUP : S_ACC_CLS_RD;
            end
            S_ACC_CLS_RD: begin
                o_cmd.op = OP_ACC_CLS_RD;
                n_state  = S_ACC_CLS;
            end
            S_ACC_CLS: begin
                o_cmd.op = OP_ACC_CLS;
                n_state  = S_ACC_RD;
            end
            S_ACC_RD: begin
                o_cmd.op = OP_ACC_RD;
                n_state  = S_ACC_WR;
            end
            S_ACC_WR: begin
                o_cmd.op = OP_ACC_WR;
                if (!i_status.d_last) n_state = S_ACC_RD;
                else n_state = i_status.w_last ? S_NORM_SETUP : S_ACC_CLS_RD;
            end
            S_NORM_SETUP: begin
                o_cmd.op = OP_NORM_SETUP;
                n_state  = S_NORM_RD;
            end
            S_NORM_RD: begin
                o_cmd.op = OP_NORM_RD;
                n_state  = S_NORM_GO;
            end
            S_NORM_GO: begin
                o_cmd.op = OP_NORM_GO;
                n_state  = S_NORM_WAIT;
            end
            S_NORM_WAIT: begin
                if (!i_status.div_busy) n_state = S_NORM_WR;
            end
            S_NORM_WR: begin
                o_cmd.op = OP_NORM_WR;
                n_state  = i_status.d_last ? S_SQRT_GO : S_NORM_RD;
            end
            S_SQRT_GO: begin
                o_cmd.op = OP_SQRT_GO;
                n_state  = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                if (!i_status.sqrt_busy) n_state = S_SQRT_END;
            end
            S_SQRT_END: begin
                o_cmd.op = OP_SQRT_END;
                n_state  = S_UNIT_RD;
            end
            S_UNIT_RD: begin
                o_cmd.op = OP_UNIT_RD;
                n_state  = S_UNIT_GO;
            end
            S_UNIT_GO: begin
                o_cmd.op = OP_UNIT_GO;
                n_state  = i_status.cent_ok ? S_UNIT_WAIT : S_UNIT_WR;
            end
            S_UNIT_WAIT: begin
                if (!i_status.div_busy) n_state = S_UNIT_WR;
            end
            S_UNIT_WR: begin
                o_cmd.op = OP_UNIT_WR;
                if (!i_status.d_last) n_state = S_UNIT_RD;
                else n_state = i_status.c_last ? S_ASG_SETUP : S_NORM_RD;
            end
            S_ASG_SETUP: begin
                o_cmd.op = OP_ASG_SETUP;
                n_state  = i_status.n_zero ? S_PASS_END : S_ASG_CLS;
            end
            S_ASG_CLS: begin
                o_cmd.op = OP_ASG_CLS;
                n_state  = i_status.cent_ok ? S_ASG_RD : S_ASG_NEXTC;
            end
            S_ASG_RD: begin
                o_cmd.op = OP_ASG_RD;
                n_state  = S_ASG_MUL;
            end
            S_ASG_MUL: begin
                o_cmd.op = OP_ASG_MUL;
                n_state  = S_ASG_ACC;
            end
            S_ASG_ACC: begin
                o_cmd.op = OP_ASG_ACC;
                n_state  = i_status.d_last ? S_ASG_CMP : S_ASG_RD;
            end
            S_ASG_CMP: begin
                o_cmd.op = OP_ASG_CMP;
                n_state  = S_ASG_NEXTC;
            end
            S_ASG_NEXTC: begin
                o_cmd.op = OP_ASG_NEXTC;
                n_state  = i_status.c_last ? S_ASG_WR : S_ASG_CLS;
            end
            S_ASG_WR: begin
                o_cmd.op = OP_ASG_WR;
                n_state  = i_status.w_last ? S_PASS_END : S_ASG_CLS;
            end
            S_PASS_END: begin
                o_cmd.op = OP_PASS_END;
                n_state  = S_PASS_START;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- sv/skm_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module skm_datapath
    import skm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    output t_status                       o_status,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic signed [ELEM_W-1:0] i_element_value,
    input  wire logic                     i_last_in_vector,
    input  wire logic [W_AW-1:0]          i_query_word,
    output logic [W_AW-1:0]               o_answered_word,
    output logic [C_AW-1:0]               o_class_id,
    output logic                          o_index_invalid
);
    logic [CC_W-1:0] r_class_count;
    logic [VL_W-1:0] r_vector_length;
    logic [PC_W-1:0] r_pass_count;

    logic [WCNT_W-1:0] r_loaded, n_loaded;
    logic [D_AW-1:0]   r_pos, n_pos;
    logic [W_AW-1:0]   r_w, n_w;
    logic [C_AW-1:0]   r_wc, n_wc;
    logic [C_AW-1:0]   r_c, n_c;
    logic [C_AW-1:0]   r_cl, n_cl;
    logic [D_AW-1:0]   r_d, n_d;
    logic [PC_W-1:0]   r_p, n_p;
    logic [W_AW-1:0]   r_qword, n_qword;
    logic              r_qbad, n_qbad;
    logic [SQ_W-1:0]   r_sq, n_sq;
    logic [SQ_W-1:0]   r_sv, n_sv;
    logic [SQ_W-1:0]   r_root, n_root;
    logic [SQ_W-1:0]   r_bit, n_bit;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [CLASSES_MAX-1:0] r_valid, n_valid;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [DOT_W-1:0]  r_x, n_x;
    logic signed [DOT_W-1:0]  r_best, n_best;
    logic [C_AW-1:0]   r_best_id, n_best_id;

    logic [C_AW:0]     w_k;
    logic [VL_W-1:0]   w_dim;
    logic [SQ_W-1:0]   w_sqt;
    logic signed [ELEM_W-1:0]   w_m;
    logic signed [2*ELEM_W-1:0] w_msq;

    logic                 vec_we;
    logic [VEC_AW-1:0]    vec_addr;
    logic signed [ELEM_W-1:0] vec_rdata;
    logic                 cent_we;
    logic [CENT_AW-1:0]   cent_addr;
    logic signed [CENT_W-1:0] cent_wdata, cent_rdata;
    logic                 memb_we;
    logic [C_AW-1:0]      memb_addr;
    logic [MEMB_W-1:0]    memb_wdata, memb_rdata;
    logic                 cls_we;
    logic [W_AW-1:0]      cls_addr;
    logic [C_AW-1:0]      cls_wdata, cls_rdata;
    logic                 div_start, div_busy;
    logic signed [NUM_W-1:0] div_num;
    logic [LEN_W-1:0]     div_den;
    logic signed [QUO_W-1:0] div_quo;

    // Register values outside the supported range are clamped.
    always_comb begin
        if (r_class_count == '0) w_k = (C_AW+1)'(1);
        else if (r_class_count > CC_W'(CLASSES_MAX)) w_k = (C_AW+1)'(CLASSES_MAX);
        else w_k = (C_AW+1)'(r_class_count);
        if (r_vector_length == '0) w_dim = VL_W'(1);
        else if (r_vector_length > VL_W'(DIM_MAX)) w_dim = VL_W'(DIM_MAX);
        else w_dim = r_vector_length;
    end

    always_comb begin
        o_status.n_zero    = r_loaded == '0;
        o_status.w_last    = (WCNT_W'(r_w) + WCNT_W'(1)) == r_loaded;
        o_status.d_last    = VL_W'(r_d) == (w_dim - VL_W'(1));
        o_status.c_last    = {1'b0, r_c} == (w_k - (C_AW+1)'(1));
        o_status.pass_done = r_p == r_pass_count;
        o_status.cent_ok   = r_valid[r_c];
        o_status.div_busy  = div_busy;
        o_status.sqrt_busy = r_bit != '0;
    end

    always_comb begin
        w_m   = cent_rdata[ELEM_W-1:0];
        w_msq = $signed(div_quo[ELEM_W-1:0]) * $signed(div_quo[ELEM_W-1:0]);
        w_sqt = r_root + r_bit;

        n_loaded = r_loaded;  n_pos = r_pos;   n_w = r_w;     n_wc = r_wc;
        n_c = r_c;            n_cl = r_cl;     n_d = r_d;     n_p = r_p;
        n_qword = r_qword;    n_qbad = r_qbad; n_sq = r_sq;   n_len = r_len;
        n_valid = r_valid;    n_prod = r_prod; n_x = r_x;
        n_best = r_best;      n_best_id = r_best_id;
        n_sv = r_sv;          n_root = r_root; n_bit = r_bit;

        vec_we = 1'b0;   vec_addr = {r_w, r_d};
        cent_we = 1'b0;  cent_addr = {r_c, r_d};  cent_wdata = '0;
        memb_we = 1'b0;  memb_addr = r_c;         memb_wdata = MEMB_W'(1);
        cls_we = 1'b0;   cls_addr = r_w;          cls_wdata = r_wc;
        div_start = 1'b0;
        div_num = NUM_W'(cent_rdata);
        div_den = LEN_W'(memb_rdata);

        // Bit-by-bit integer square root, one result bit per cycle.
        if (r_bit != '0) begin
            if (r_sv >= w_sqt) begin
                n_sv   = r_sv - w_sqt;
                n_root = (r_root >> 1) + r_bit;
            end else begin
                n_root = r_root >> 1;
            end
            n_bit = r_bit >> 2;
        end

        case (i_cmd.op) inside
            OP_LOAD: begin
                vec_addr = {r_loaded[W_AW-1:0], r_pos};
                if (r_loaded < WCNT_W'(WORDS_MAX)) begin
                    vec_we = 1'b1;
                    if (i_last_in_vector) begin
                        n_loaded = r_loaded + WCNT_W'(1);
                        n_pos    = '0;
                    end else if (r_pos != D_AW'(DIM_MAX - 1)) begin
                        n_pos = r_pos + D_AW'(1);
                    end
                end
            end
            OP_QUERY: begin
                cls_addr = i_query_word;
                n_qword  = i_query_word;
                n_qbad   = WCNT_W'(i_query_word) >= r_loaded;
            end
            OP_INIT_SETUP: begin
                n_w = '0; n_wc = '0; n_p = '0;
            end
            OP_INIT_WR: begin
                cls_we = 1'b1;
                n_w    = r_w + W_AW'(1);
                n_wc   = ({1'b0, r_wc} == w_k - (C_AW+1)'(1)) ? '0 : r_wc + C_AW'(1);
            end
            OP_PASS_SETUP, OP_NORM_SETUP: begin
                n_c = '0; n_d = '0; n_sq = '0;
            end
            OP_CLR: begin
                cent_we = 1'b1;
                memb_we = 1'b1;
                if (o_status.d_last) begin
                    n_d = '0;
                    n_c = r_c + C_AW'(1);
                end else begin
                    n_d = r_d + D_AW'(1);
                end
            end
            OP_ACC_SETUP: begin
                n_w = '0;
            end
            OP_ACC_CLS_RD: begin
                cls_addr = r_w;
            end
            OP_ACC_CLS: begin
                n_cl = cls_rdata;
                n_d  = '0;
            end
            OP_ACC_RD: begin
                cent_addr = {r_cl, r_d};
                memb_addr = r_cl;
            end
            OP_ACC_WR: begin
                cent_addr  = {r_cl, r_d};
                memb_addr  = r_cl;
                cent_we    = 1'b1;
                cent_wdata = cent_rdata + CENT_W'(vec_rdata);
                memb_wdata = memb_rdata + MEMB_W'(1);
                if (o_status.d_last) begin
                    memb_we = 1'b1;
                    n_d = '0;
                    n_w = r_w + W_AW'(1);
                end else begin
                    n_d = r_d + D_AW'(1);
                end
            end
            OP_NORM_GO: begin
                div_start = 1'b1;
            end
            OP_NORM_WR: begin
                cent_we    = 1'b1;
                cent_wdata = CENT_W'($signed(div_quo[ELEM_W-1:0]));
                n_sq       = r_sq + SQ_W'($unsigned(w_msq));
                n_d        = o_status.d_last ? '0 : r_d + D_AW'(1);
            end
            OP_SQRT_GO: begin
                n_sv   = r_sq;
                n_root = '0;
                n_bit  = SQ_W'(1) << (SQ_W - 2);
                n_sq   = '0;
            end
            OP_SQRT_END: begin
                n_len        = r_root[LEN_W-1:0];
                n_valid[r_c] = r_root != '0;
                n_d          = '0;
            end
            OP_UNIT_GO: begin
                div_num   = NUM_W'(w_m) <<< UNIT_SHIFT;
                div_den   = r_len;
                div_start = r_valid[r_c];
            end
            OP_UNIT_WR: begin
                cent_we    = 1'b1;
                cent_wdata = r_valid[r_c] ? CENT_W'(div_quo) : '0;
                if (o_status.d_last) begin
                    n_d = '0;
                    n_c = r_c + C_AW'(1);
                end else begin
                    n_d = r_d + D_AW'(1);
                end
            end
            OP_ASG_SETUP: begin
                n_w = '0; n_c = '0; n_best = BEST_INIT; n_best_id = '0;
            end
            OP_ASG_CLS: begin
                n_d = '0; n_x = '0;
            end
            OP_ASG_MUL: begin
                n_prod = cent_rdata * vec_rdata;
            end
            OP_ASG_ACC: begin
                n_x = r_x + DOT_W'(r_prod);
                n_d = o_status.d_last ? '0 : r_d + D_AW'(1);
            end
            OP_ASG_CMP: begin
                if (r_x > r_best) begin
                    n_best    = r_x;
                    n_best_id = r_c;
                end
            end
            OP_ASG_NEXTC: begin
                n_c = r_c + C_AW'(1);
            end
            OP_ASG_WR: begin
                cls_we    = 1'b1;
                cls_wdata = r_best_id;
                n_w       = r_w + W_AW'(1);
                n_c       = '0;
                n_best    = BEST_INIT;
                n_best_id = '0;
            end
            OP_PASS_END: begin
                n_p = r_p + PC_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_count   <= CLASS_COUNT_RST;
            r_vector_length <= VECTOR_LENGTH_RST;
            r_pass_count    <= PASS_COUNT_RST;
            r_loaded        <= '0;
            r_pos           <= '0;
            r_bit           <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_CLASS_COUNT:   r_class_count   <= i_cfg_data[CC_W-1:0];
                    REG_VECTOR_LENGTH: r_vector_length <= i_cfg_data[VL_W-1:0];
                    REG_PASS_COUNT:    r_pass_count    <= i_cfg_data[PC_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_loaded <= n_loaded;
            r_pos    <= n_pos;
            r_bit    <= n_bit;
        end
        r_w <= n_w;         r_wc <= n_wc;       r_c <= n_c;       r_cl <= n_cl;
        r_d <= n_d;         r_p <= n_p;         r_qword <= n_qword;
        r_qbad <= n_qbad;   r_sq <= n_sq;       r_sv <= n_sv;     r_root <= n_root;
        r_len <= n_len;     r_valid <= n_valid; r_prod <= n_prod; r_x <= n_x;
        r_best <= n_best;   r_best_id <= n_best_id;
    end

    skm_ram #(.WIDTH(ELEM_W), .DEPTH(WORDS_MAX * DIM_MAX)) u_vec_ram (
        .i_clk(i_clk), .i_we(vec_we), .i_addr(vec_addr),
        .i_wdata(i_element_value), .o_rdata(vec_rdata)
    );

    skm_ram #(.WIDTH(CENT_W), .DEPTH(CLASSES_MAX * DIM_MAX)) u_cent_ram (
        .i_clk(i_clk), .i_we(cent_we), .i_addr(cent_addr),
        .i_wdata(cent_wdata), .o_rdata(cent_rdata)
    );

    skm_ram #(.WIDTH(MEMB_W), .DEPTH(CLASSES_MAX)) u_memb_ram (
        .i_clk(i_clk), .i_we(memb_we), .i_addr(memb_addr),
        .i_wdata(memb_wdata), .o_rdata(memb_rdata)
    );

    skm_ram #(.WIDTH(C_AW), .DEPTH(WORDS_MAX)) u_cls_ram (
        .i_clk(i_clk), .i_we(cls_we), .i_addr(cls_addr),
        .i_wdata(cls_wdata), .o_rdata(cls_rdata)
    );

    skm_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_busy(div_busy), .o_quo(div_quo)
    );

    assign o_answered_word = r_qword;
    assign o_index_invalid = r_qbad;
    assign o_class_id      = r_qbad ? '0 : cls_rdata;
endmodule
`default_nettype wire

// ----- sv/spherical_kmeans_clustering_unit.sv -----
// Spherical k-means clustering over word vectors held in on-chip memory.
// Commands are offered on start and taken on a clock edge where busy is low.
// A load (operation 0) writes one signed Q4.12 element and is taken at one
// per cycle while busy is low; marking the last element of the last word
// starts clustering. A query (operation 1) shows its result on the output
// ports for exactly one cycle, flagged by o_result_valid, in the cycle after
// the command was taken. Loads give no result. The receiver cannot stall.
// Clustering keeps busy high while it runs. Each pass clears the class sums,
// sums the loaded words into their classes, turns each sum into a mean and
// scales it to unit length (through the 47-step serial divider and the
// 20-step root unit), and then assigns each of the n loaded words to one of
// the k classes, comparing dot products over dim elements per vector.
// Registers are written on the configuration channel, which is always ready;
// write them only while busy is low and no query is pending.
// Reset clears word count, element position and controller and restores the
// register defaults; stored vectors and classes are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module spherical_kmeans_clustering_unit
    import skm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     i_operation,
    input  wire logic signed [ELEM_W-1:0] i_element_value,
    input  wire logic                     i_last_in_vector,
    input  wire logic                     i_last_vector,
    input  wire logic [W_AW-1:0]          i_query_word,
    output logic                          o_result_valid,
    output logic [W_AW-1:0]               o_answered_word,
    output logic [C_AW-1:0]               o_class_id,
    output logic                          o_index_invalid,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    i_cfg_data
);
    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    skm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_operation(i_operation), .i_last_in_vector(i_last_in_vector),
        .i_last_vector(i_last_vector), .i_status(status), .o_cmd(cmd),
        .o_busy(busy), .o_result_valid(o_result_valid)
    );

    skm_datapath u_datapath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_cfg_we(i_cfg_valid && o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .i_element_value(i_element_value),
        .i_last_in_vector(i_last_in_vector), .i_query_word(i_query_word),
        .o_answered_word(o_answered_word), .o_class_id(o_class_id),
        .o_index_invalid(o_index_invalid)
    );

`ifndef ASSERT_OFF
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result shown while a command could be taken");

    a_result_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result held for more than one cycle");

    a_query_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation) |=> o_result_valid)
        else $error("query transaction gave no result");

    a_invalid_class_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_index_invalid) |-> (o_class_id == '0))
        else $error("invalid index reported a non-zero class");
`endif
endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import skm_pkg::*;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic                     i_operation;
    logic signed [ELEM_W-1:0] i_element_value;
    logic                     i_last_in_vector;
    logic                     i_last_vector;
    logic [W_AW-1:0]          i_query_word;
    logic                     o_result_valid;
    logic [W_AW-1:0]          o_answered_word;
    logic [C_AW-1:0]          o_class_id;
    logic                     o_index_invalid;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;

    spherical_kmeans_clustering_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_element_value (i_element_value),
        .i_last_in_vector(i_last_in_vector),
        .i_last_vector   (i_last_vector),
        .i_query_word    (i_query_word),
        .o_result_valid  (o_result_valid),
        .o_answered_word (o_answered_word),
        .o_class_id      (o_class_id),
        .o_index_invalid (o_index_invalid),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct {
        logic [W_AW-1:0] word;
        logic [C_AW-1:0] cls;
        logic            inv;
    } answer_t;

    typedef struct {
        bit                     op;
        logic signed [ELEM_W-1:0] val;
        bit                     li;
        bit                     lv;
        logic [W_AW-1:0]        q;
        int                     rep;
        bit                     typed;
        logic [C_AW-1:0]        cls;
        bit                     inv;
    } step_t;

    answer_t answers_due[$];

    // Own copy of the clustering state.
    shortint          vec_mem [WORDS_MAX*DIM_MAX];
    int               word_class [WORDS_MAX];
    longint           cent [CLASSES_MAX*DIM_MAX];
    int               members [CLASSES_MAX];
    bit               cent_ok [CLASSES_MAX];
    int               words_in, elem_pos, clustered_words;
    logic [CC_W-1:0]  cfg_classes;
    logic [VL_W-1:0]  cfg_length;
    logic [PC_W-1:0]  cfg_passes;

    int fails, n_loads, n_queries, n_clusterings, burst_left;
    bit steady;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root, bit_v;
        root = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= root + bit_v) begin
                v = v - root - bit_v;
                root = (root >> 1) + bit_v;
            end else begin
                root >>= 1;
            end
            bit_v >>= 2;
        end
        return root;
    endfunction

    function automatic void recluster();
        int k, dim, n, w, c, d, p, cl, best_id;
        longint unsigned sq, len;
        longint len_s, m, x, best;
        k = (cfg_classes < 1) ? 1 : ((cfg_classes > CLASSES_MAX) ? CLASSES_MAX : cfg_classes);
        dim = (cfg_length < 1) ? 1 : ((cfg_length > DIM_MAX) ? DIM_MAX : cfg_length);
        n = words_in;
        for (w = 0; w < n; w++) word_class[w] = w % k;
        for (p = 0; p < int'(cfg_passes); p++) begin
            for (c = 0; c < k; c++) begin
                members[c] = 1;
                for (d = 0; d < dim; d++) cent[c*DIM_MAX+d] = 0;
            end
            for (w = 0; w < n; w++) begin
                cl = word_class[w] % k;
                for (d = 0; d < dim; d++)
                    cent[cl*DIM_MAX+d] += longint'(vec_mem[w*DIM_MAX+d]);
                members[cl]++;
            end
            for (c = 0; c < k; c++) begin
                sq = 0;
                for (d = 0; d < dim; d++) begin
                    m = cent[c*DIM_MAX+d] / longint'(members[c]);
                    cent[c*DIM_MAX+d] = m;
                    sq += longint'(m * m);
                end
                len = int_sqrt(sq);
                len_s = longint'(len);
                cent_ok[c] = (len != 0);
                for (d = 0; d < dim; d++)
                    cent[c*DIM_MAX+d] = cent_ok[c]
                        ? (cent[c*DIM_MAX+d] * 64'sd1073741824) / len_s : 64'sd0;
            end
            for (w = 0; w < n; w++) begin
                best = -64'sd10 * (64'sd1 << 42);
                best_id = 0;
                for (c = 0; c < k; c++) begin
                    if (!cent_ok[c]) continue;
                    x = 0;
                    for (d = 0; d < dim; d++)
                        x += cent[c*DIM_MAX+d] * longint'(vec_mem[w*DIM_MAX+d]);
                    if (x > best) begin
                        best = x;
                        best_id = c;
                    end
                end
                word_class[w] = best_id;
            end
        end
    endfunction

    // Returns 1 when the transaction produces an answer.
    function automatic bit predict_item(input bit op, input logic signed [ELEM_W-1:0] val,
                                        input bit li, input bit lv, input logic [W_AW-1:0] q,
                                        output answer_t a);
        int pos;
        if (!op) begin
            if (words_in < WORDS_MAX) begin
                pos = (elem_pos < DIM_MAX) ? elem_pos : DIM_MAX - 1;
                vec_mem[words_in*DIM_MAX+pos] = val;
                if (li) begin
                    words_in++;
                    elem_pos = 0;
                end else if (elem_pos < DIM_MAX - 1) begin
                    elem_pos++;
                end
            end
            if (li && lv) begin
                recluster();
                clustered_words = words_in;
                n_clusterings++;
            end
            return 1'b0;
        end
        a.word = q;
        a.inv = (int'(q) >= words_in);
        a.cls = a.inv ? '0 : word_class[q][C_AW-1:0];
        return 1'b1;
    endfunction

    task automatic send(input bit op, input logic signed [ELEM_W-1:0] val, input bit li,
                        input bit lv, input logic [W_AW-1:0] q, input bit typed,
                        input answer_t typed_ans);
        answer_t a;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!steady && $urandom_range(0, 2) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        start            <= 1'b1;
        i_operation      <= op;
        i_element_value  <= val;
        i_last_in_vector <= li;
        i_last_vector    <= lv;
        i_query_word     <= q;
        do @(posedge i_clk); while (busy);
        if (op) n_queries++; else n_loads++;
        if (predict_item(op, val, li, lv, q, a))
            answers_due.push_back(typed ? typed_ans : a);
    endtask

    task automatic settle();
        start <= 1'b0;
        repeat (4) @(posedge i_clk);
        while (busy || answers_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_CLASS_COUNT:   cfg_classes = data[CC_W-1:0];
            REG_VECTOR_LENGTH: cfg_length  = data[VL_W-1:0];
            REG_PASS_COUNT:    cfg_passes  = data[PC_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic configure(input int k, input int dim, input int passes);
        settle();
        cfg_write(REG_CLASS_COUNT, CFG_DATA_W'(k));
        cfg_write(REG_VECTOR_LENGTH, CFG_DATA_W'(dim));
        cfg_write(REG_PASS_COUNT, CFG_DATA_W'(passes));
    endtask

    function automatic logic signed [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // Unless fresh is set, never asks for a loaded word that has not been through clustering.
    function automatic logic [W_AW-1:0] pick_query(input bit fresh);
        if (clustered_words > 0 && (words_in >= WORDS_MAX || $urandom_range(0, 3) != 0))
            return W_AW'($urandom_range(0, fresh ? words_in - 1 : clustered_words - 1));
        return W_AW'($urandom_range(words_in, WORDS_MAX - 1));
    endfunction

    // Load a batch of words, the last one closing the set, with queries mixed in.
    task automatic run_phase(input int k, input int dim, input int passes, input int nwords,
                             input int min_el, input int max_el);
        int w, e, elems;
        bit li;
        answer_t none;
        none = '{word: '0, cls: '0, inv: 1'b0};
        configure(k, dim, passes);
        steady = ($urandom_range(0, 3) == 0);
        for (w = 0; w < nwords; w++) begin
            elems = $urandom_range(min_el, max_el);
            for (e = 0; e < elems; e++) begin
                if ($urandom_range(0, 5) == 0)
                    send(1'b1, rand_elem(), $urandom_range(0, 1), $urandom_range(0, 1),
                         pick_query(1'b0), 1'b0, none);
                li = (e == elems - 1);
                send(1'b0, rand_elem(), li, li ? (w == nwords - 1) : $urandom_range(0, 1),
                     W_AW'($urandom), 1'b0, none);
            end
        end
        for (e = 0; e < 30; e++)
            send(1'b1, rand_elem(), $urandom_range(0, 1), $urandom_range(0, 1),
                 pick_query(1'b1), 1'b0, none);
    endtask

    always @(posedge i_clk) begin
        if (o_result_valid) begin
            if (answers_due.size() == 0) begin
                $error("answer with none outstanding: word %0d", o_answered_word);
                fails++;
            end else begin
                automatic answer_t exp_a = answers_due.pop_front();
                if (o_answered_word !== exp_a.word) begin
                    $error("answered_word: expected %0d, got %0d", exp_a.word, o_answered_word);
                    fails++;
                end
                if (o_class_id !== exp_a.cls) begin
                    $error("class_id: expected %0d, got %0d", exp_a.cls, o_class_id);
                    fails++;
                end
                if (o_index_invalid !== exp_a.inv) begin
                    $error("index_invalid: expected %0b, got %0b", exp_a.inv, o_index_invalid);
                    fails++;
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("spherical_kmeans_clustering_unit test failed");
        $finish;
    end

    initial begin
        step_t script [16];
        answer_t ans;
        int i, r;
        script = '{
            '{1'b1, 16'sh0000, 1'b0, 1'b0, 12'd0,    1,   1'b1, 6'd0, 1'b1},
            '{1'b1, 16'shFFFF, 1'b1, 1'b1, 12'd4095, 1,   1'b1, 6'd0, 1'b1},
            // Stray last_vector marks without last_in_vector must not start clustering.
            '{1'b0, 16'sh7FFF, 1'b0, 1'b1, 12'd4095, 127, 1'b0, 6'd0, 1'b0},
            '{1'b0, 16'sh8000, 1'b1, 1'b0, 12'd0,    1,   1'b0, 6'd0, 1'b0},
            // Overlong vector: surplus elements land on the last slot.
            '{1'b0, 16'sh8000, 1'b0, 1'b0, 12'd0,    129, 1'b0, 6'd0, 1'b0},
            '{1'b0, 16'sh7FFF, 1'b1, 1'b0, 12'd0,    1,   1'b0, 6'd0, 1'b0},
            '{1'b0, 16'sh0000, 1'b0, 1'b0, 12'd0,    64,  1'b0, 6'd0, 1'b0},
            '{1'b0, 16'sh0001, 1'b0, 1'b0, 12'd0,    63,  1'b0, 6'd0, 1'b0},
            '{1'b0, 16'shFFFF, 1'b1, 1'b1, 12'd0,    1,   1'b0, 6'd0, 1'b0},
            // With no passes every word stays in its initial class.
            '{1'b1, 16'sh0000, 1'b0, 1'b0, 12'd0,    1,   1'b1, 6'd0, 1'b0},
            '{1'b1, 16'sh0000, 1'b0, 1'b0, 12'd1,    1,   1'b1, 6'd0, 1'b0},
            '{1'b1, 16'sh0000, 1'b0, 1'b0, 12'd2,    1,   1'b1, 6'd0, 1'b0},
            '{1'b1, 16'sh0000, 1'b0, 1'b0, 12'd3,    1,   1'b1, 6'd0, 1'b1},
            '{1'b1, 16'sh7FFF, 1'b1, 1'b1, 12'd4095, 1,   1'b1, 6'd0, 1'b1},
            '{1'b1, 16'sh0000, 1'b0, 1'b0, 12'd2048, 1,   1'b1, 6'd0, 1'b1},
            '{1'b1, 16'sh0000, 1'b0, 1'b0, 12'd1365, 1,   1'b1, 6'd0, 1'b1}
        };
        fails = 0; n_loads = 0; n_queries = 0; n_clusterings = 0;
        burst_left = 0; steady = 1'b0;
        words_in = 0; elem_pos = 0; clustered_words = 0;
        cfg_classes = CLASS_COUNT_RST;
        cfg_length  = VECTOR_LENGTH_RST;
        cfg_passes  = PASS_COUNT_RST;
        i_rst_n          <= 1'b0;
        start            <= 1'b0;
        i_operation      <= 1'b0;
        i_element_value  <= '0;
        i_last_in_vector <= 1'b0;
        i_last_vector    <= 1'b0;
        i_query_word     <= '0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= '0;
        i_cfg_data       <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Out-of-range register values exercise the clamping.
        configure(0, 255, 0);
        for (i = 0; i < 16; i++) begin
            ans = '{word: script[i].q, cls: script[i].cls, inv: script[i].inv};
            for (r = 0; r < script[i].rep; r++)
                send(script[i].op, script[i].val, script[i].li, script[i].lv, script[i].q,
                     script[i].typed, ans);
        end

        // Vector lengths never grow, so no clustering reads an unwritten element.
        run_phase(2,   128, 1,  4,  128, 131);
        run_phase(4,   8,   15, 20, 8,   10);
        run_phase(127, 1,   2,  30, 1,   3);
        run_phase(5,   0,   3,  40, 1,   2);
        run_phase(64,  1,   1,  10, 1,   2);
        settle();

        $display("Covered %0d loads, %0d queries and %0d clustering runs over %0d words.",
                 n_loads, n_queries, n_clusterings, words_in);
        if (fails == 0) begin
            $display("spherical_kmeans_clustering_unit test passed");
        end else begin
            $display("spherical_kmeans_clustering_unit test failed");
        end
        $finish;
    end

endmodule
